/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define SGS_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// next-cycle implication, masked while reset is high
`define SGS_ASSERT_NXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define SGS_ASSERT_NXT_ALL(label, clk, lhs, rhs) \
  label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

/* rtl/core/sgs_pkg.sv */
package sgs_pkg;

  // grid geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_RADIUS = 7;
  localparam int XW         = 6;
  localparam int YW         = 6;
  localparam int AW         = XW + YW;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_W      = AW + 1;

  // cell codes
  localparam logic [1:0] CELL_EMPTY = 2'd0;
  localparam logic [1:0] CELL_RED   = 2'd1;
  localparam logic [1:0] CELL_BLUE  = 2'd2;
  localparam logic [1:0] CELL_BAD   = 2'd3;

  // operation codes of an input word
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_REBUILD = 2'd2;
  localparam logic [1:0] OP_STEP    = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RADIUS = 3'd2;
  localparam logic [2:0] CFG_THRESH = 3'd3;
  localparam logic [2:0] CFG_FILL   = 3'd4;
  localparam logic [2:0] CFG_SEED   = 3'd5;

  // configuration reset values
  localparam logic [6:0]  RST_WIDTH  = 7'd50;
  localparam logic [6:0]  RST_HEIGHT = 7'd50;
  localparam logic [2:0]  RST_RADIUS = 3'd1;
  localparam logic [8:0]  RST_THRESH = 9'd102;
  localparam logic [31:0] RST_SEED   = 32'd1;

  // datapath commands
  typedef enum logic [4:0] {
    DP_IDLE, DP_CLEAR, DP_LOAD, DP_WRITE, DP_READ_ISSUE, DP_READ_TAKE,
    DP_REB_INIT, DP_CEN_RD, DP_REB_CHK, DP_STEP_INIT, DP_SCAN_INIT, DP_ADV,
    DP_NB_INIT, DP_NB, DP_NB_DRAIN, DP_EVAL_STEP, DP_EVAL_FILL, DP_FILL_END,
    DP_SET_SETTLED, DP_MV_INIT, DP_MV_RD, DP_MV_SLOT, DP_MV_WR1, DP_MV_WR2,
    DP_PUSH
  } dp_op_t;

  // datapath status
  typedef struct packed {
    logic [1:0] gq;
    logic       last_cell;
    logic       nb_last;
    logic       et_zero;
    logic       ut_zero;
    logic       k_last;
    logic       rem_busy;
    logic       clr_last;
    logic       fill_en;
  } dp_status_t;

endpackage

/* rtl/core/sgs_rem.sv */
module sgs_rem (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [12:0] divisor,
  output logic        busy,
  output logic [12:0] rem
);

  logic [31:0] q;
  logic [13:0] r;
  logic [4:0]  cnt;
  logic [13:0] r_shift;
  logic [13:0] r_next;

  // one restoring step per cycle
  always_comb begin
    r_shift = {r[12:0], q[31]};
    if (r_shift >= {1'b0, divisor}) begin
      r_next = r_shift - {1'b0, divisor};
    end else begin
      r_next = r_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      q    <= dividend;
      r    <= '0;
    end else if (busy) begin
      r   <= r_next;
      q   <= {q[30:0], 1'b0};
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  assign rem = r[12:0];

endmodule

/* rtl/core/sgs_datapath.sv */
module sgs_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sgs_pkg::dp_op_t     cmd,
  output sgs_pkg::dp_status_t status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [5:0]          cell_x,
  input  logic [5:0]          cell_y,
  input  logic [1:0]          cell_value,
  output logic [1:0]          cell_out,
  output logic                settled,
  output logic [12:0]         moved_count
);

  // configuration
  logic [6:0]  width_cells;
  logic [6:0]  height_cells;
  logic [2:0]  radius;
  logic [8:0]  threshold_q8;
  logic        fill_enable;

  // working registers
  logic [sgs_pkg::AW-1:0]    addr_q;
  logic [1:0]                val_q;
  logic [5:0]                cx;
  logic [5:0]                cy;
  logic signed [4:0]         ox;
  logic signed [4:0]         oy;
  logic [7:0]                nr;
  logic [7:0]                nb;
  logic                      pv;
  logic [1:0]                cc;
  logic [sgs_pkg::CNT_W-1:0] et;
  logic [sgs_pkg::CNT_W-1:0] ut;
  logic [sgs_pkg::CNT_W-1:0] k;
  logic [31:0]               rng;
  logic [sgs_pkg::AW-1:0]    slot;
  logic [1:0]                rd_val;
  logic                      set_settled;
  logic                      set_moved;
  logic [sgs_pkg::AW-1:0]    clr_cnt;

  // memories
  logic [1:0]             grid_mem  [sgs_pkg::CELLS];
  logic [sgs_pkg::AW-1:0] empty_mem [sgs_pkg::CELLS];
  logic [sgs_pkg::AW-1:0] unh_mem   [sgs_pkg::CELLS];
  logic [1:0]             gq;
  logic [sgs_pkg::AW-1:0] eq;
  logic [sgs_pkg::AW-1:0] uq;

  // derived values
  logic [6:0]             w_used;
  logic [6:0]             h_used;
  logic [2:0]             r_used;
  logic signed [4:0]      rr;
  logic signed [7:0]      nx;
  logic signed [7:0]      ny;
  logic                   nb_in;
  logic [sgs_pkg::AW-1:0] nb_addr;
  logic [sgs_pkg::AW-1:0] cen_addr;
  logic                   last_col;
  logic                   last_cell;
  logic [7:0]             n_tot;
  logic [7:0]             own;
  logic [16:0]            thr_prod;
  logic                   unhappy;
  logic [31:0]            rng_adv;
  logic                   rem_busy;
  logic [12:0]            rem;

  // grid port controls
  logic                   g_we;
  logic                   g_re;
  logic [sgs_pkg::AW-1:0] g_addr;
  logic [1:0]             g_wd;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // clipped configuration
  always_comb begin
    if (width_cells == 7'd0) begin
      w_used = 7'd1;
    end else if (width_cells > 7'(sgs_pkg::MAX_WIDTH)) begin
      w_used = 7'(sgs_pkg::MAX_WIDTH);
    end else begin
      w_used = width_cells;
    end
    if (height_cells == 7'd0) begin
      h_used = 7'd1;
    end else if (height_cells > 7'(sgs_pkg::MAX_HEIGHT)) begin
      h_used = 7'(sgs_pkg::MAX_HEIGHT);
    end else begin
      h_used = height_cells;
    end
    if (radius > 3'(sgs_pkg::MAX_RADIUS)) begin
      r_used = 3'(sgs_pkg::MAX_RADIUS);
    end else begin
      r_used = radius;
    end
  end

  // neighbour address and clipping
  always_comb begin
    rr       = $signed({2'b00, r_used});
    nx       = $signed({2'b00, cx}) + 8'(ox);
    ny       = $signed({2'b00, cy}) + 8'(oy);
    nb_in    = !nx[7] && !ny[7] && (nx < $signed({1'b0, w_used}))
               && (ny < $signed({1'b0, h_used})) && !(ox == 5'sd0 && oy == 5'sd0);
    nb_addr  = {ny[5:0], nx[5:0]};
    cen_addr = {cy, cx};
    last_col = ({1'b0, cx} == w_used - 7'd1);
    last_cell = last_col && ({1'b0, cy} == h_used - 7'd1);
  end

  // happiness test
  always_comb begin
    n_tot    = nr + nb;
    own      = (cc == sgs_pkg::CELL_RED) ? nr : nb;
    thr_prod = 17'(threshold_q8 * n_tot);
    unhappy  = (n_tot != 8'd0) && ({1'b0, own, 8'd0} < thr_prod);
    rng_adv  = xorshift(rng);
  end

  // grid port selection
  always_comb begin
    g_we   = 1'b0;
    g_re   = 1'b0;
    g_addr = cen_addr;
    g_wd   = sgs_pkg::CELL_EMPTY;
    case (cmd)
      sgs_pkg::DP_CLEAR: begin
        g_we   = 1'b1;
        g_addr = clr_cnt;
      end
      sgs_pkg::DP_WRITE: begin
        g_we   = 1'b1;
        g_addr = addr_q;
        g_wd   = (val_q == sgs_pkg::CELL_BAD) ? sgs_pkg::CELL_EMPTY : val_q;
      end
      sgs_pkg::DP_READ_ISSUE: begin
        g_re   = 1'b1;
        g_addr = addr_q;
      end
      sgs_pkg::DP_CEN_RD: begin
        g_re = 1'b1;
      end
      sgs_pkg::DP_NB: begin
        g_re   = 1'b1;
        g_addr = nb_addr;
      end
      sgs_pkg::DP_EVAL_FILL: begin
        g_we = 1'b1;
        g_wd = (nr > nb) ? sgs_pkg::CELL_RED : sgs_pkg::CELL_BLUE;
      end
      sgs_pkg::DP_MV_SLOT: begin
        g_re   = 1'b1;
        g_addr = uq;
      end
      sgs_pkg::DP_MV_WR1: begin
        g_we   = 1'b1;
        g_addr = eq;
        g_wd   = gq;
      end
      sgs_pkg::DP_MV_WR2: begin
        g_we   = 1'b1;
        g_addr = uq;
      end
      default: begin
        g_we = 1'b0;
      end
    endcase
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_addr] <= g_wd;
    end
    if (g_re) begin
      gq <= grid_mem[g_addr];
    end
  end

  // empty slot list
  always_ff @(posedge clk) begin
    if (cmd == sgs_pkg::DP_REB_CHK && gq == sgs_pkg::CELL_EMPTY) begin
      empty_mem[et[sgs_pkg::AW-1:0]] <= cen_addr;
    end else if (cmd == sgs_pkg::DP_MV_WR1) begin
      empty_mem[slot] <= uq;
    end
    if (cmd == sgs_pkg::DP_MV_SLOT) begin
      eq <= empty_mem[rem[sgs_pkg::AW-1:0]];
    end
  end

  // unhappy agent list
  always_ff @(posedge clk) begin
    if (cmd == sgs_pkg::DP_EVAL_STEP && unhappy) begin
      unh_mem[ut[sgs_pkg::AW-1:0]] <= cen_addr;
    end
    if (cmd == sgs_pkg::DP_MV_RD) begin
      uq <= unh_mem[k[sgs_pkg::AW-1:0]];
    end
  end

  // slot draw remainder
  sgs_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd == sgs_pkg::DP_MV_RD),
    .dividend (rng_adv),
    .divisor  (et),
    .busy     (rem_busy),
    .rem      (rem)
  );

  // configuration and generator
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cells  <= sgs_pkg::RST_WIDTH;
      height_cells <= sgs_pkg::RST_HEIGHT;
      radius       <= sgs_pkg::RST_RADIUS;
      threshold_q8 <= sgs_pkg::RST_THRESH;
      fill_enable  <= 1'b0;
      rng          <= sgs_pkg::RST_SEED;
    end else if (cfg_we) begin
      case (cfg_index)
        sgs_pkg::CFG_WIDTH:  width_cells  <= cfg_data[6:0];
        sgs_pkg::CFG_HEIGHT: height_cells <= cfg_data[6:0];
        sgs_pkg::CFG_RADIUS: radius       <= cfg_data[2:0];
        sgs_pkg::CFG_THRESH: threshold_q8 <= cfg_data[8:0];
        sgs_pkg::CFG_FILL:   fill_enable  <= cfg_data[0];
        sgs_pkg::CFG_SEED:   rng          <= cfg_data;
        default: begin
        end
      endcase
    end else if (cmd == sgs_pkg::DP_MV_RD) begin
      rng <= rng_adv;
    end
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      et          <= '0;
      ut          <= '0;
      clr_cnt     <= '0;
      cell_out    <= '0;
      settled     <= 1'b0;
      moved_count <= '0;
    end else begin
      case (cmd)
        sgs_pkg::DP_CLEAR: begin
          clr_cnt <= clr_cnt + sgs_pkg::AW'(1);
        end
        sgs_pkg::DP_LOAD: begin
          addr_q      <= {cell_y, cell_x};
          val_q       <= cell_value;
          rd_val      <= sgs_pkg::CELL_EMPTY;
          set_settled <= 1'b0;
          set_moved   <= 1'b0;
        end
        sgs_pkg::DP_READ_TAKE: begin
          rd_val <= gq;
        end
        sgs_pkg::DP_REB_INIT: begin
          cx <= '0;
          cy <= '0;
          et <= '0;
        end
        sgs_pkg::DP_STEP_INIT: begin
          cx <= '0;
          cy <= '0;
          ut <= '0;
        end
        sgs_pkg::DP_SCAN_INIT: begin
          cx <= '0;
          cy <= '0;
        end
        sgs_pkg::DP_REB_CHK: begin
          if (gq == sgs_pkg::CELL_EMPTY) begin
            et <= et + sgs_pkg::CNT_W'(1);
          end
          if (last_col) begin
            cx <= '0;
            cy <= cy + 6'd1;
          end else begin
            cx <= cx + 6'd1;
          end
        end
        sgs_pkg::DP_ADV, sgs_pkg::DP_EVAL_FILL: begin
          if (last_col) begin
            cx <= '0;
            cy <= cy + 6'd1;
          end else begin
            cx <= cx + 6'd1;
          end
        end
        sgs_pkg::DP_EVAL_STEP: begin
          if (unhappy) begin
            ut <= ut + sgs_pkg::CNT_W'(1);
          end
          if (last_col) begin
            cx <= '0;
            cy <= cy + 6'd1;
          end else begin
            cx <= cx + 6'd1;
          end
        end
        sgs_pkg::DP_NB_INIT: begin
          ox <= -rr;
          oy <= -rr;
          nr <= '0;
          nb <= '0;
          pv <= 1'b0;
          cc <= gq;
        end
        sgs_pkg::DP_NB: begin
          pv <= nb_in;
          if (pv && gq == sgs_pkg::CELL_RED) begin
            nr <= nr + 8'd1;
          end else if (pv && gq == sgs_pkg::CELL_BLUE) begin
            nb <= nb + 8'd1;
          end
          if (ox == rr) begin
            ox <= -rr;
            oy <= oy + 5'sd1;
          end else begin
            ox <= ox + 5'sd1;
          end
        end
        sgs_pkg::DP_NB_DRAIN: begin
          pv <= 1'b0;
          if (pv && gq == sgs_pkg::CELL_RED) begin
            nr <= nr + 8'd1;
          end else if (pv && gq == sgs_pkg::CELL_BLUE) begin
            nb <= nb + 8'd1;
          end
        end
        sgs_pkg::DP_FILL_END: begin
          et <= '0;
        end
        sgs_pkg::DP_SET_SETTLED: begin
          set_settled <= 1'b1;
        end
        sgs_pkg::DP_MV_INIT: begin
          k         <= '0;
          set_moved <= 1'b1;
        end
        sgs_pkg::DP_MV_SLOT: begin
          slot <= rem[sgs_pkg::AW-1:0];
        end
        sgs_pkg::DP_MV_WR2: begin
          k <= k + sgs_pkg::CNT_W'(1);
        end
        sgs_pkg::DP_PUSH: begin
          cell_out    <= rd_val;
          settled     <= set_settled;
          moved_count <= set_moved ? ut : '0;
        end
        default: begin
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    status.gq        = gq;
    status.last_cell = last_cell;
    status.nb_last   = (ox == rr) && (oy == rr);
    status.et_zero   = (et == '0);
    status.ut_zero   = (ut == '0);
    status.k_last    = (k == ut - sgs_pkg::CNT_W'(1));
    status.rem_busy  = rem_busy;
    status.clr_last  = (clr_cnt == sgs_pkg::AW'(sgs_pkg::CELLS - 1));
    status.fill_en   = fill_enable;
  end

endmodule

/* rtl/core/sgs_ctrl.sv */
module sgs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  output logic                out_valid,
  input  logic                out_ready,
  input  sgs_pkg::dp_status_t status,
  output sgs_pkg::dp_op_t     cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_WR, S_RD, S_RD2, S_RB_INIT, S_RB_RD, S_RB_CHK, S_ST_INIT,
    S_SC_RD, S_SC_CHK, S_NB, S_NB_DRAIN, S_EVAL, S_PASS_END, S_FILL_INIT,
    S_MV_INIT, S_MV_RD, S_MV_WAIT, S_MV_SLOT, S_MV_WR1, S_MV_WR2, S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   fill_mode;
  logic   want;
  logic   push;

  assign in_ready = (state == S_IDLE);
  assign push     = (state == S_FIN) && (!out_valid || out_ready);

  // sequencing and command decode
  always_comb begin
    state_next = state;
    cmd        = sgs_pkg::DP_IDLE;
    want       = fill_mode ? (status.gq == sgs_pkg::CELL_EMPTY)
                           : (status.gq != sgs_pkg::CELL_EMPTY);
    case (state)
      S_CLR: begin
        cmd = sgs_pkg::DP_CLEAR;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd = sgs_pkg::DP_LOAD;
          case (op)
            sgs_pkg::OP_WRITE:   state_next = S_WR;
            sgs_pkg::OP_READ:    state_next = S_RD;
            sgs_pkg::OP_REBUILD: state_next = S_RB_INIT;
            default:             state_next = S_ST_INIT;
          endcase
        end
      end
      S_WR: begin
        cmd        = sgs_pkg::DP_WRITE;
        state_next = S_FIN;
      end
      S_RD: begin
        cmd        = sgs_pkg::DP_READ_ISSUE;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd        = sgs_pkg::DP_READ_TAKE;
        state_next = S_FIN;
      end
      S_RB_INIT: begin
        cmd        = sgs_pkg::DP_REB_INIT;
        state_next = S_RB_RD;
      end
      S_RB_RD: begin
        cmd        = sgs_pkg::DP_CEN_RD;
        state_next = S_RB_CHK;
      end
      S_RB_CHK: begin
        cmd        = sgs_pkg::DP_REB_CHK;
        state_next = status.last_cell ? S_FIN : S_RB_RD;
      end
      S_ST_INIT: begin
        if (status.et_zero) begin
          cmd        = sgs_pkg::DP_SET_SETTLED;
          state_next = S_FIN;
        end else begin
          cmd        = sgs_pkg::DP_STEP_INIT;
          state_next = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd        = sgs_pkg::DP_CEN_RD;
        state_next = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (want) begin
          cmd        = sgs_pkg::DP_NB_INIT;
          state_next = S_NB;
        end else begin
          cmd        = sgs_pkg::DP_ADV;
          state_next = status.last_cell ? S_PASS_END : S_SC_RD;
        end
      end
      S_NB: begin
        cmd = sgs_pkg::DP_NB;
        if (status.nb_last) state_next = S_NB_DRAIN;
      end
      S_NB_DRAIN: begin
        cmd        = sgs_pkg::DP_NB_DRAIN;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd        = fill_mode ? sgs_pkg::DP_EVAL_FILL : sgs_pkg::DP_EVAL_STEP;
        state_next = status.last_cell ? S_PASS_END : S_SC_RD;
      end
      S_PASS_END: begin
        if (fill_mode) begin
          cmd        = sgs_pkg::DP_FILL_END;
          state_next = S_FIN;
        end else if (status.ut_zero) begin
          cmd        = sgs_pkg::DP_SET_SETTLED;
          state_next = status.fill_en ? S_FILL_INIT : S_FIN;
        end else begin
          cmd        = sgs_pkg::DP_MV_INIT;
          state_next = S_MV_RD;
        end
      end
      S_FILL_INIT: begin
        cmd        = sgs_pkg::DP_SCAN_INIT;
        state_next = S_SC_RD;
      end
      S_MV_INIT: begin
        cmd        = sgs_pkg::DP_MV_INIT;
        state_next = S_MV_RD;
      end
      S_MV_RD: begin
        cmd        = sgs_pkg::DP_MV_RD;
        state_next = S_MV_WAIT;
      end
      S_MV_WAIT: begin
        if (!status.rem_busy) state_next = S_MV_SLOT;
      end
      S_MV_SLOT: begin
        cmd        = sgs_pkg::DP_MV_SLOT;
        state_next = S_MV_WR1;
      end
      S_MV_WR1: begin
        cmd        = sgs_pkg::DP_MV_WR1;
        state_next = S_MV_WR2;
      end
      S_MV_WR2: begin
        cmd        = sgs_pkg::DP_MV_WR2;
        state_next = status.k_last ? S_FIN : S_MV_RD;
      end
      S_FIN: begin
        if (push) begin
          cmd        = sgs_pkg::DP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      fill_mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ST_INIT) begin
        fill_mode <= 1'b0;
      end else if (state == S_FILL_INIT) begin
        fill_mode <= 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/segregation_grid_step.sv */
// Schelling segregation grid of 64 x 64 two-bit cells (empty, red, blue) with
// one word in and one word out per operation. After reset a clearing pass
// writes every grid cell empty; in_ready stays low meanwhile, configuration
// writes are taken at any time. A rebuild reads the used area once, reading
// and checking each cell in turn. A step is bounded by the single grid port:
// every agent gets a neighbourhood scan over its (2r+1)^2 window, every other
// cell a read and a check, and each move waits on the bit-serial remainder
// unit that draws the destination slot (32 steps). When fill is enabled and a
// step settles, a second scan runs over the empty cells. A finished word
// waits in the output register while the next word is accepted.
module segregation_grid_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [1:0]  cell_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  cell_out,
  output logic        settled,
  output logic [12:0] moved_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  sgs_pkg::dp_op_t     cmd;
  sgs_pkg::dp_status_t status;

  // sequencer
  sgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // grid, lists and counters
  sgs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_value  (cell_value),
    .cell_out    (cell_out),
    .settled     (settled),
    .moved_count (moved_count)
  );

endmodule

/* rtl/core/sgs_checker.sv */
`include "assert_macros.svh"

module sgs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  cell_out,
  input logic        settled,
  input logic [12:0] moved_count
);

  logic [15:0] out_word;

  // whole result word as one vector
  assign out_word = {cell_out, settled, moved_count};

  // a waiting word holds
  `SGS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // a step either settles or moves agents, never both
  `SGS_ASSERT_IMP(a_settle_move, clk, rst, out_valid && settled, moved_count == 13'd0)

  // read data comes only with a plain read word
  `SGS_ASSERT_IMP(a_read_alone, clk, rst, out_valid && cell_out != sgs_pkg::CELL_EMPTY, !settled && moved_count == 13'd0)

  // no word is taken just after reset, when the clearing pass starts
  `SGS_ASSERT_NXT_ALL(a_clear_busy, clk, rst, !in_ready)

endmodule

bind segregation_grid_step sgs_checker u_sgs_checker (.*);
